// ===== src/assert_macros.svh =====
// Assertion helpers used by the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/rbme_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rbme_pkg;

  typedef struct packed {
    logic signed [31:0] value;
    logic [62:0]        value_squared;
    logic               restart;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] running_mean;
    logic [31:0]        running_error;
    logic [15:0]        item_index;
    logic               error_valid;
    logic               saturated;
  } out_item_t;

  // Divider request, and status from the divider and square-root units
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  localparam int unsigned DivW = 64;

endpackage
`default_nettype wire

// ===== src/rbme_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Restoring unsigned divider, one quotient bit per cycle
module rbme_div (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire rbme_pkg::div_ctl_t    ctl,
  input  wire logic [63:0]           dividend,
  input  wire logic [16:0]           divisor,
  output      rbme_pkg::unit_sts_t   sts,
  output      logic [63:0]           quotient
);
  import rbme_pkg::*;

  logic [63:0] q_r, q_nxt;
  logic [17:0] rem_r, rem_nxt;
  logic [16:0] dvs_r, dvs_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [17:0] trial;
  logic [17:0] shifted;

  assign shifted = {rem_r[16:0], q_r[63]};
  assign trial   = shifted - {1'b0, dvs_r};

  // Shift one dividend bit in, subtract where it fits
  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (ctl.start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = 7'(DivW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[17]) begin
        rem_nxt = trial;
        q_nxt   = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        q_nxt   = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = q_r;
endmodule
`default_nettype wire

// ===== src/rbme_sqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Bit-pair integer square root, two radicand bits per cycle
module rbme_sqrt (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [63:0]           radicand,
  output      rbme_pkg::unit_sts_t   sts,
  output      logic [31:0]           root
);
  import rbme_pkg::*;

  logic [63:0] x_r, x_nxt;
  logic [33:0] rem_r, rem_nxt;
  logic [31:0] root_r, root_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [33:0] acc;
  logic [33:0] trial;

  assign acc   = {rem_r[31:0], x_r[63:62]};
  assign trial = acc - {root_r, 2'b01};

  // Bring down two bits, try the next root bit
  always_comb begin
    x_nxt    = x_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      x_nxt    = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = 6'd32;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      x_nxt = {x_r[61:0], 2'b00};
      if (!trial[33]) begin
        rem_nxt  = trial;
        root_nxt = {root_r[30:0], 1'b1};
      end else begin
        rem_nxt  = acc;
        root_nxt = {root_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign root     = root_r;
endmodule
`default_nettype wire

// ===== src/running_block_mean_error.sv =====
// Running block mean and standard error.
// Input channel in_valid/in_stall/in_data carries one block result per
// request: value (Q16.16), value_squared (Q31.32) and restart. Output
// channel out_valid/out_stall/out_data returns one request per input with
// the progressive mean, standard error, item index and flags.
// One item is worked at a time. Each item is added, then its mean is
// found by a serial division (one quotient bit a cycle) on a shared
// divider; from the second item of a run, two more divisions on it and
// a square root (two radicand bits a cycle) give the standard error.
// in_stall stays high from acceptance until the result is taken, so a
// new item is accepted only after the result of the last has left.
// A stalled result holds in the output register; no new item is taken
// until it has left. Reset clears the sums, the count and the sticky
// saturation flag and drops any item in flight. The restart bit clears
// the same state before its item is added. After MAX_ITEMS items the
// count holds, items are not added, and saturated is raised.
`timescale 1ns / 1ps
`default_nettype none
module running_block_mean_error #(
  parameter int unsigned MAX_ITEMS = 65536
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output      logic                  in_stall,
  input  wire rbme_pkg::in_item_t    in_data,
  output      logic                  out_valid,
  input  wire logic                  out_stall,
  output      rbme_pkg::out_item_t   out_data
);
  import rbme_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ADD   = 4'd1;
  localparam logic [3:0] S_MDIV  = 4'd2;
  localparam logic [3:0] S_MWAIT = 4'd3;
  localparam logic [3:0] S_SDIV  = 4'd4;
  localparam logic [3:0] S_SWAIT = 4'd5;
  localparam logic [3:0] S_MSQ   = 4'd6;
  localparam logic [3:0] S_VDIV  = 4'd7;
  localparam logic [3:0] S_VWAIT = 4'd8;
  localparam logic [3:0] S_RT    = 4'd9;
  localparam logic [3:0] S_RWAIT = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  localparam logic signed [47:0] TotMax = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] TotMin = {1'b1, {47{1'b0}}};
  localparam logic [16:0] MaxCnt = 17'(MAX_ITEMS);

  logic [3:0]         st_r, st_nxt;
  logic signed [47:0] vtot_r, vtot_nxt;
  logic [63:0]        stot_r, stot_nxt;
  logic [16:0]        cnt_r, cnt_nxt;
  logic               lim_r, lim_nxt;
  in_item_t           item_r;
  logic               neg_r, neg_nxt;
  logic signed [31:0] mean_r, mean_nxt;
  logic [63:0]        tmp_r, tmp_nxt;
  logic [31:0]        err_r, err_nxt;
  logic               ov_r;
  out_item_t          out_r;
  logic               ov_nxt;

  logic [63:0]        div_a;
  logic [16:0]        div_b;
  div_ctl_t           div_ctl;
  unit_sts_t          div_sts;
  logic [63:0]        div_q;
  logic               rt_start;
  unit_sts_t          rt_sts;
  logic [31:0]        rt_q;

  logic signed [47:0] bv_tot;
  logic [63:0]        bs_tot;
  logic [16:0]        b_cnt;
  logic               b_lim;
  logic signed [48:0] t_sum;
  logic [64:0]        s_sum;
  logic [47:0]        abs_tot;
  logic [31:0]        abs_mean;
  logic [63:0]        msq;
  logic               accept;

  rbme_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (div_a),
    .divisor  (div_b),
    .sts      (div_sts),
    .quotient (div_q)
  );

  rbme_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rt_start),
    .radicand (tmp_r),
    .sts      (rt_sts),
    .root     (rt_q)
  );

  assign accept   = in_valid && !in_stall;
  assign in_stall = (st_r != S_IDLE) || ov_r;
  assign abs_tot  = vtot_r[47] ? 48'(-vtot_r) : vtot_r;
  assign abs_mean = mean_r[31] ? 32'(-mean_r) : mean_r;
  assign msq      = {32'd0, abs_mean} * {32'd0, abs_mean};

  // Apply restart ahead of the add
  always_comb begin
    bv_tot = vtot_r;
    bs_tot = stot_r;
    b_cnt  = cnt_r;
    b_lim  = lim_r;
    if (item_r.restart) begin
      bv_tot = '0;
      bs_tot = '0;
      b_cnt  = '0;
      b_lim  = 1'b0;
    end
    t_sum = 49'(bv_tot) + 49'(item_r.value);
    s_sum = {1'b0, bs_tot} + {2'b00, item_r.value_squared};
  end

  // Sequence the add, the mean division and, from the second item, two more divisions and the root
  always_comb begin
    st_nxt   = st_r;
    vtot_nxt = vtot_r;
    stot_nxt = stot_r;
    cnt_nxt  = cnt_r;
    lim_nxt  = lim_r;
    neg_nxt  = neg_r;
    mean_nxt = mean_r;
    tmp_nxt  = tmp_r;
    err_nxt  = err_r;
    div_ctl  = '0;
    div_a    = '0;
    div_b    = cnt_r;
    rt_start = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        if (accept) st_nxt = S_ADD;
      end
      S_ADD: begin
        vtot_nxt = bv_tot;
        stot_nxt = bs_tot;
        cnt_nxt  = b_cnt;
        lim_nxt  = b_lim;
        if (b_cnt >= MaxCnt) begin
          lim_nxt = 1'b1;
        end else begin
          cnt_nxt = b_cnt + 17'd1;
          if (t_sum > 49'(TotMax)) begin
            vtot_nxt = TotMax;
            lim_nxt  = 1'b1;
          end else if (t_sum < 49'(TotMin)) begin
            vtot_nxt = TotMin;
            lim_nxt  = 1'b1;
          end else begin
            vtot_nxt = t_sum[47:0];
          end
          if (s_sum[64]) begin
            stot_nxt = '1;
            lim_nxt  = 1'b1;
          end else begin
            stot_nxt = s_sum[63:0];
          end
        end
        st_nxt = S_MDIV;
      end
      S_MDIV: begin
        neg_nxt     = vtot_r[47];
        div_a       = {16'd0, abs_tot};
        div_ctl.start = 1'b1;
        st_nxt      = S_MWAIT;
      end
      S_MWAIT: begin
        if (div_sts.done) begin
          // Clamp the truncated quotient to the signed range
          if (neg_r) begin
            if (div_q > 64'h8000_0000) mean_nxt = 32'sh8000_0000;
            else mean_nxt = 32'(-div_q);
          end else begin
            if (div_q > 64'h7FFF_FFFF) mean_nxt = 32'sh7FFF_FFFF;
            else mean_nxt = div_q[31:0];
          end
          err_nxt = '0;
          if (cnt_r >= 17'd2) st_nxt = S_SDIV;
          else st_nxt = S_OUT;
        end
      end
      S_SDIV: begin
        div_a         = stot_r;
        div_ctl.start = 1'b1;
        st_nxt        = S_SWAIT;
      end
      S_SWAIT: begin
        if (div_sts.done) begin
          tmp_nxt = div_q;
          st_nxt  = S_MSQ;
        end
      end
      S_MSQ: begin
        tmp_nxt = (tmp_r > msq) ? (tmp_r - msq) : 64'd0;
        st_nxt  = S_VDIV;
      end
      S_VDIV: begin
        div_a         = tmp_r;
        div_b         = cnt_r - 17'd1;
        div_ctl.start = 1'b1;
        st_nxt        = S_VWAIT;
      end
      S_VWAIT: begin
        if (div_sts.done) begin
          tmp_nxt = div_q;
          st_nxt  = S_RT;
        end
      end
      S_RT: begin
        rt_start = 1'b1;
        st_nxt   = S_RWAIT;
      end
      S_RWAIT: begin
        if (rt_sts.done) begin
          err_nxt = rt_q;
          st_nxt  = S_OUT;
        end
      end
      S_OUT: begin
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // Output register: load on finish, drop once taken
  always_comb begin
    ov_nxt = ov_r;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    if (st_r == S_OUT) ov_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    neg_r  <= neg_nxt;
    mean_r <= mean_nxt;
    tmp_r  <= tmp_nxt;
    err_r  <= err_nxt;
    if (accept) item_r <= in_data;
    if (st_r == S_OUT) begin
      out_r.running_mean  <= mean_r;
      out_r.running_error <= err_r;
      out_r.item_index    <= 16'(cnt_r - 17'd1);
      out_r.error_valid   <= (cnt_r >= 17'd2);
      out_r.saturated     <= lim_r;
    end
    if (!rst_n) begin
      st_r   <= S_IDLE;
      vtot_r <= '0;
      stot_r <= '0;
      cnt_r  <= '0;
      lim_r  <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      vtot_r <= vtot_nxt;
      stot_r <= stot_nxt;
      cnt_r  <= cnt_nxt;
      lim_r  <= lim_nxt;
      ov_r   <= ov_nxt;
    end
  end

  assign out_valid = ov_r;
  assign out_data  = out_r;
endmodule
`default_nettype wire

// ===== src/rbme_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Port-level checks on the running mean block
module rbme_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire rbme_pkg::out_item_t out_data
);
  import rbme_pkg::*;

  // Hold a stalled result
  `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
  // Take no request while a result is waiting
  `CHK_IMPLY(a_one_in_flight, clk, rst_n, out_valid, in_stall, "request taken while result pending")
  // An accepted request blocks the input next cycle
  `CHK_NEXT(a_busy_after_req, clk, rst_n, in_valid && !in_stall, in_stall, "input open after request")
  // Error is zero whenever it is flagged invalid
  `CHK_IMPLY(a_err_zero, clk, rst_n, out_valid && !out_data.error_valid, out_data.running_error == 32'd0, "error nonzero while invalid")
endmodule

bind running_block_mean_error rbme_checker u_rbme_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
